// ----- rtl/core/jta_pkg.sv -----
package jta_pkg;

  localparam int LOG_CAPACITY_DEF = 32;
  localparam logic [6:0] OPEN_MAX = 7'd127;

  localparam logic [31:0] LOG_START_RST     = 32'd2;
  localparam logic [6:0]  LOG_AREA_SIZE_RST = 7'd33;
  localparam logic [5:0]  MAX_OP_BLOCKS_RST = 6'd10;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_END   = 2'd1,
    OP_WRITE = 2'd2,
    OP_DONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    RS_GRANTED      = 4'd0,
    RS_WAIT         = 4'd1,
    RS_RELEASED     = 4'd2,
    RS_COMMIT_EMPTY = 4'd3,
    RS_COMMIT_BLOCK = 4'd4,
    RS_ADDED        = 4'd5,
    RS_ABSORBED     = 4'd6,
    RS_DONE_OK      = 4'd7,
    RS_TOO_BIG      = 4'd8,
    RS_OUTSIDE      = 4'd9,
    RS_END_COMMIT   = 4'd10,
    RS_NO_COMMIT    = 4'd11,
    RS_UNBALANCED   = 4'd12
  } status_t;

  typedef enum logic [1:0] {
    REG_LOG_START     = 2'd0,
    REG_LOG_AREA_SIZE = 2'd1,
    REG_MAX_OP_BLOCKS = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_EMIT_RD,
    S_EMIT_WAIT
  } state_t;

  typedef struct packed {
    logic [31:0] log_start;
    logic [6:0]  log_area_size;
    logic [5:0]  max_op_blocks;
  } cfg_t;

  typedef struct packed {
    logic committing;
    logic busy;
  } ctrl_stat_t;

endpackage

// ----- rtl/core/jta_req_if.sv -----
interface jta_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] block_number;

  modport source(output valid, output operation, output block_number, input ready);
  modport sink(input valid, input operation, input block_number, output ready);
endinterface

// ----- rtl/core/jta_rsp_if.sv -----
interface jta_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [31:0] home_block;
  logic [5:0]  slot_index;
  logic [31:0] log_address;
  logic        pin_request;
  logic        last;

  modport source(output valid, output status, output home_block, output slot_index,
                 output log_address, output pin_request, output last, input ready);
  modport sink(input valid, input status, input home_block, input slot_index,
               input log_address, input pin_request, input last, output ready);
endinterface

// ----- rtl/core/jta_log_ram.sv -----
module jta_log_ram #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [31:0]       wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [31:0]       rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/jta_ctrl.sv -----
module jta_ctrl #(
  parameter int LOG_CAPACITY = jta_pkg::LOG_CAPACITY_DEF,
  parameter int SLOT_W       = $clog2(LOG_CAPACITY)
) (
  input  logic                    clk,
  input  logic                    rst,
  jta_req_if.sink                 req,
  jta_rsp_if.source               rsp,
  input  jta_pkg::cfg_t           cfg,
  output logic                    mem_we,
  output logic [SLOT_W-1:0]       mem_waddr,
  output logic [31:0]             mem_wdata,
  output logic                    mem_re,
  output logic [SLOT_W-1:0]       mem_raddr,
  input  logic [31:0]             mem_rdata,
  output jta_pkg::ctrl_stat_t     stat
);

  import jta_pkg::*;

  localparam int CNT_W = $clog2(LOG_CAPACITY + 1);

  state_t            state, state_next;
  logic [6:0]        open_ops;
  logic              committing;
  logic [CNT_W-1:0]  count;
  logic [31:0]       blk_reg;
  logic [CNT_W-1:0]  srch_idx;
  logic              cmp_pend;
  logic [SLOT_W-1:0] cmp_idx;
  logic [CNT_W-1:0]  emit_idx;

  logic              out_valid;
  status_t           out_status;
  logic [31:0]       out_home;
  logic [5:0]        out_slot;
  logic [31:0]       out_addr;
  logic              out_pin;
  logic              out_last;

  logic              accept, out_free;
  op_t               op;
  logic [7:0]        open_plus;
  logic [13:0]       prod;
  logic [14:0]       need;
  logic              table_full, issue_now, hit, emit_last;

  logic              ld, ld_has_addr, ld_pin, ld_last;
  status_t           ld_status;
  logic [31:0]       ld_home;
  logic [SLOT_W-1:0] ld_slot;
  logic              open_inc, open_dec, commit_set, commit_clr, cnt_inc, cnt_clr;
  logic              srch_start, emit_adv;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign op        = op_t'(req.operation);

  // Worst-case space with one more operation open.
  assign open_plus  = {1'b0, open_ops} + 8'd1;
  assign prod       = 14'(open_plus) * 14'(cfg.max_op_blocks);
  assign need       = 15'(prod) + 15'(count);
  assign table_full = (count >= CNT_W'(LOG_CAPACITY)) ||
                      ((8'(count) + 8'd1) >= 8'(cfg.log_area_size));

  assign issue_now = srch_idx < count;
  assign hit       = cmp_pend && (mem_rdata == blk_reg);
  assign emit_last = (emit_idx + CNT_W'(1)) == count;

  always_comb begin
    ld          = 1'b0;
    ld_status   = RS_GRANTED;
    ld_home     = '0;
    ld_slot     = '0;
    ld_has_addr = 1'b0;
    ld_pin      = 1'b0;
    ld_last     = 1'b1;
    mem_re      = 1'b0;
    mem_raddr   = srch_idx[SLOT_W-1:0];
    mem_we      = 1'b0;
    open_inc    = 1'b0;
    open_dec    = 1'b0;
    commit_set  = 1'b0;
    commit_clr  = 1'b0;
    cnt_inc     = 1'b0;
    cnt_clr     = 1'b0;
    srch_start  = 1'b0;
    emit_adv    = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_BEGIN: begin
              ld = 1'b1;
              if (committing || open_ops == OPEN_MAX || need > 15'(LOG_CAPACITY)) begin
                ld_status = RS_WAIT;
              end else begin
                ld_status = RS_GRANTED;
                open_inc  = 1'b1;
              end
            end
            OP_END: begin
              if (committing) begin
                ld        = 1'b1;
                ld_status = RS_END_COMMIT;
              end else if (open_ops == '0) begin
                ld        = 1'b1;
                ld_status = RS_UNBALANCED;
              end else begin
                open_dec = 1'b1;
                if (open_ops != 7'd1) begin
                  ld        = 1'b1;
                  ld_status = RS_RELEASED;
                end else if (count == '0) begin
                  ld        = 1'b1;
                  ld_status = RS_COMMIT_EMPTY;
                end else begin
                  commit_set = 1'b1;
                end
              end
            end
            OP_WRITE: begin
              if (table_full) begin
                ld        = 1'b1;
                ld_status = RS_TOO_BIG;
              end else if (open_ops == '0) begin
                ld        = 1'b1;
                ld_status = RS_OUTSIDE;
              end else begin
                srch_start = 1'b1;
              end
            end
            OP_DONE: begin
              ld = 1'b1;
              if (!committing) begin
                ld_status = RS_NO_COMMIT;
              end else begin
                ld_status  = RS_DONE_OK;
                cnt_clr    = 1'b1;
                commit_clr = 1'b1;
              end
            end
            default: begin
              ld = 1'b0;
            end
          endcase
        end
      end
      S_SEARCH: begin
        mem_re    = issue_now;
        mem_raddr = srch_idx[SLOT_W-1:0];
        if (hit) begin
          ld          = 1'b1;
          ld_status   = RS_ABSORBED;
          ld_home     = blk_reg;
          ld_slot     = cmp_idx;
          ld_has_addr = 1'b1;
        end else if (!issue_now) begin
          ld          = 1'b1;
          ld_status   = RS_ADDED;
          ld_home     = blk_reg;
          ld_slot     = count[SLOT_W-1:0];
          ld_has_addr = 1'b1;
          ld_pin      = 1'b1;
          mem_we      = 1'b1;
          cnt_inc     = 1'b1;
        end
      end
      S_EMIT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = emit_idx[SLOT_W-1:0];
      end
      S_EMIT_WAIT: begin
        if (out_free) begin
          ld          = 1'b1;
          ld_status   = RS_COMMIT_BLOCK;
          ld_home     = mem_rdata;
          ld_slot     = emit_idx[SLOT_W-1:0];
          ld_has_addr = 1'b1;
          ld_last     = emit_last;
          if (!emit_last) begin
            mem_re    = 1'b1;
            mem_raddr = SLOT_W'(emit_idx + CNT_W'(1));
            emit_adv  = 1'b1;
          end
        end
      end
      default: begin
        ld = 1'b0;
      end
    endcase
  end

  assign mem_waddr = count[SLOT_W-1:0];
  assign mem_wdata = blk_reg;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (srch_start) begin
          state_next = S_SEARCH;
        end else if (commit_set) begin
          state_next = S_EMIT_RD;
        end
      end
      S_SEARCH: begin
        if (hit || !issue_now) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_free && emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      open_ops   <= '0;
      committing <= 1'b0;
      count      <= '0;
      cmp_pend   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (open_inc) begin
        open_ops <= open_ops + 7'd1;
      end else if (open_dec) begin
        open_ops <= open_ops - 7'd1;
      end
      if (commit_set) begin
        committing <= 1'b1;
      end else if (commit_clr) begin
        committing <= 1'b0;
      end
      if (cnt_clr) begin
        count <= '0;
      end else if (cnt_inc) begin
        count <= count + CNT_W'(1);
      end
      if (srch_start) begin
        cmp_pend <= 1'b0;
      end else if (state == S_SEARCH) begin
        cmp_pend <= issue_now;
      end
      if (ld) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (srch_start) begin
      blk_reg  <= req.block_number;
      srch_idx <= '0;
    end else if (state == S_SEARCH) begin
      cmp_idx <= srch_idx[SLOT_W-1:0];
      if (issue_now) begin
        srch_idx <= srch_idx + CNT_W'(1);
      end
    end
    if (commit_set) begin
      emit_idx <= '0;
    end else if (emit_adv) begin
      emit_idx <= emit_idx + CNT_W'(1);
    end
    if (ld) begin
      out_status <= ld_status;
      out_home   <= ld_home;
      out_slot   <= 6'(ld_slot);
      out_addr   <= ld_has_addr ? (cfg.log_start + 32'(ld_slot) + 32'd1) : 32'd0;
      out_pin    <= ld_pin;
      out_last   <= ld_last;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.home_block  = out_home;
  assign rsp.slot_index  = out_slot;
  assign rsp.log_address = out_addr;
  assign rsp.pin_request = out_pin;
  assign rsp.last        = out_last;

  assign stat.committing = committing;
  assign stat.busy       = state != S_IDLE;

endmodule

// ----- rtl/core/journal_transaction_admission_core.sv -----
// Transaction admission controller of a write-ahead journal.
// The req channel carries one word per request: an operation (begin, end,
// record write, commit done) and a home block number used by record writes.
// The rsp channel returns status words; every request yields exactly one
// word except an end that starts a commit, which yields one word per logged
// block, in slot order, with last set on the final one.
// The configuration port (cfg_we, cfg_index, cfg_data) writes log_start,
// log_area_size and max_op_blocks; write it only while the block is idle.
// Begin, end, commit done and rejected writes answer in the cycle after
// acceptance. A record write scans the block table through the log
// memory at one entry per cycle, and its word follows the scan. A commit
// reads its first block in the emit-read state and offers it from the
// emit-wait state; the rest follow at one word per cycle from the same
// memory while the receiver takes them.
// Requests are taken one at a time; req.ready is high only while the
// controller is idle and the output register is empty or being emptied.
// When the receiver stalls, the pending word holds in the output register
// and commit emission pauses until it is taken.
// Reset clears the counters, the committing flag and the output register,
// and restores the configuration defaults. The table needs no clearing pass.
module journal_transaction_admission_core #(
  parameter int LOG_CAPACITY = jta_pkg::LOG_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  jta_req_if.sink     req,
  jta_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  import jta_pkg::*;

  localparam int SLOT_W = $clog2(LOG_CAPACITY);

  cfg_t              cfg;
  ctrl_stat_t        stat;
  logic              mem_we, mem_re;
  logic [SLOT_W-1:0] mem_waddr, mem_raddr;
  logic [31:0]       mem_wdata, mem_rdata;

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.log_start     <= LOG_START_RST;
      cfg.log_area_size <= LOG_AREA_SIZE_RST;
      cfg.max_op_blocks <= MAX_OP_BLOCKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOG_START:     cfg.log_start     <= cfg_data;
        REG_LOG_AREA_SIZE: cfg.log_area_size <= cfg_data[6:0];
        REG_MAX_OP_BLOCKS: cfg.max_op_blocks <= cfg_data[5:0];
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  jta_ctrl #(
    .LOG_CAPACITY(LOG_CAPACITY),
    .SLOT_W(SLOT_W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata),
    .stat(stat)
  );

  jta_log_ram #(
    .DEPTH(LOG_CAPACITY),
    .ADDR_W(SLOT_W)
  ) u_log_ram (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // A commit block word can only be on the output while a commit runs.
  a_block_in_commit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == RS_COMMIT_BLOCK |-> stat.committing)
    else $error("commit block word outside a commit");

  // A commit starts only on an accepted end request.
  a_commit_start: assert property (@(posedge clk) disable iff (rst)
    $rose(stat.committing) |->
      $past(req.valid && req.ready && req.operation == OP_END))
    else $error("commit started without an end request");

  // Pinning is requested only for a newly added block.
  a_pin_added: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.pin_request |-> rsp.status == RS_ADDED)
    else $error("pin request on a word that did not add a block");

  // Nothing is offered or in progress right after reset.
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp.valid && !stat.busy)
    else $error("activity right after reset");

endmodule

// ----- tb/journal_admission_checker.sv -----
module journal_admission_checker #(
  parameter int LOG_CAPACITY = jta_pkg::LOG_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic [1:0]  operation,
  input  logic [31:0] block_number,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  logic [3:0]  status,
  input  logic [31:0] home_block,
  input  logic [5:0]  slot_index,
  input  logic [31:0] log_address,
  input  logic        pin_request,
  input  logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          outstanding,
  output int          failures
);
  import jta_pkg::*;

  typedef struct {
    status_t     status;
    logic [31:0] home;
    logic [5:0]  slot;
    logic [31:0] addr;
    logic        pin;
    logic        last;
  } journal_word_t;

  // Shadow of the configuration registers.
  logic [31:0] log_base;
  int          area_blocks;
  int          op_worst_case;

  // Shadow of the transaction state.
  int          open_ops;
  bit          committing;
  int          logged_cnt;
  logic [31:0] logged_table [LOG_CAPACITY];

  journal_word_t expected_words [$];

  function automatic journal_word_t word_of(input status_t s, input logic [31:0] home,
                                            input int slot, input bit with_addr,
                                            input bit pin, input bit fin);
    journal_word_t w;
    w.status = s;
    w.home   = home;
    w.slot   = 6'(slot);
    w.addr   = with_addr ? log_base + 32'(slot) + 32'd1 : 32'd0;
    w.pin    = pin;
    w.last   = fin;
    return w;
  endfunction

  task automatic reset_model();
    log_base      = LOG_START_RST;
    area_blocks   = int'(LOG_AREA_SIZE_RST);
    op_worst_case = int'(MAX_OP_BLOCKS_RST);
    open_ops      = 0;
    committing    = 1'b0;
    logged_cnt    = 0;
    expected_words.delete();
  endtask

  task automatic apply_config();
    case (reg_idx_t'(cfg_index))
      REG_LOG_START:     log_base = cfg_data;
      REG_LOG_AREA_SIZE: area_blocks = int'(cfg_data[6:0]);
      REG_MAX_OP_BLOCKS: op_worst_case = int'(cfg_data[5:0]);
      default: ;
    endcase
  endtask

  // Works out the words that one accepted request causes and queues them.
  task automatic predict_request(input op_t op, input logic [31:0] blk);
    int need;
    int i;
    int hit;
    case (op)
      OP_BEGIN: begin
        need = logged_cnt + (open_ops + 1) * op_worst_case;
        if (committing || open_ops >= int'(OPEN_MAX) || need > LOG_CAPACITY) begin
          expected_words.push_back(word_of(RS_WAIT, '0, 0, 0, 0, 1));
        end else begin
          open_ops++;
          expected_words.push_back(word_of(RS_GRANTED, '0, 0, 0, 0, 1));
        end
      end
      OP_END: begin
        if (committing) begin
          expected_words.push_back(word_of(RS_END_COMMIT, '0, 0, 0, 0, 1));
        end else if (open_ops == 0) begin
          expected_words.push_back(word_of(RS_UNBALANCED, '0, 0, 0, 0, 1));
        end else begin
          open_ops--;
          if (open_ops != 0) begin
            expected_words.push_back(word_of(RS_RELEASED, '0, 0, 0, 0, 1));
          end else if (logged_cnt == 0) begin
            expected_words.push_back(word_of(RS_COMMIT_EMPTY, '0, 0, 0, 0, 1));
          end else begin
            committing = 1'b1;
            for (i = 0; i < logged_cnt && i < LOG_CAPACITY; i++)
              expected_words.push_back(word_of(RS_COMMIT_BLOCK, logged_table[i], i, 1, 0,
                                               i + 1 == logged_cnt));
          end
        end
      end
      OP_WRITE: begin
        if (logged_cnt >= LOG_CAPACITY || logged_cnt + 1 >= area_blocks) begin
          expected_words.push_back(word_of(RS_TOO_BIG, '0, 0, 0, 0, 1));
        end else if (open_ops == 0) begin
          expected_words.push_back(word_of(RS_OUTSIDE, '0, 0, 0, 0, 1));
        end else begin
          hit = -1;
          for (i = 0; i < logged_cnt; i++)
            if (hit < 0 && logged_table[i] == blk) hit = i;
          if (hit >= 0) begin
            expected_words.push_back(word_of(RS_ABSORBED, blk, hit, 1, 0, 1));
          end else begin
            logged_table[logged_cnt] = blk;
            expected_words.push_back(word_of(RS_ADDED, blk, logged_cnt, 1, 1, 1));
            logged_cnt++;
          end
        end
      end
      default: begin
        if (!committing) begin
          expected_words.push_back(word_of(RS_NO_COMMIT, '0, 0, 0, 0, 1));
        end else begin
          logged_cnt = 0;
          committing = 1'b0;
          expected_words.push_back(word_of(RS_DONE_OK, '0, 0, 0, 0, 1));
        end
      end
    endcase
  endtask

  task automatic check_word();
    journal_word_t want;
    bit bad;
    if (expected_words.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected rsp word: status %0d home %h slot %0d addr %h pin %b last %b",
                 status, home_block, slot_index, log_address, pin_request, last);
      return;
    end
    want = expected_words.pop_front();
    bad = (status !== want.status) || (home_block !== want.home) ||
          (slot_index !== want.slot) || (log_address !== want.addr) ||
          (pin_request !== want.pin) || (last !== want.last);
    if (bad) begin
      failures++;
      if (failures <= 10) begin
        $display("rsp mismatch, expected: status %0d home %h slot %0d addr %h pin %b last %b",
                 want.status, want.home, want.slot, want.addr, want.pin, want.last);
        $display("                actual: status %0d home %h slot %0d addr %h pin %b last %b",
                 status, home_block, slot_index, log_address, pin_request, last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
    end else begin
      if (cfg_we) apply_config();
      if (rsp_valid && rsp_ready) check_word();
      if (req_valid && req_ready) predict_request(op_t'(operation), block_number);
    end
    outstanding <= expected_words.size();
  end

endmodule

// ----- tb/journal_transaction_admission_core_test.sv -----
module journal_transaction_admission_core_test;
  import jta_pkg::*;

  // Length of the deliberate receiver hold-off, in clock cycles.
  localparam int LONG_HOLD_CYCLES = 300;
  // Number of request words that the random sections aim for, in three parts.
  localparam int RANDOM_WORDS = 60;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int failures;
  int outstanding;

  // When steady is set, neither the sender nor the receiver inserts idle cycles.
  bit steady;
  // Each increment asks the receiver process for one long hold-off.
  int long_hold_req;
  // Count of request words accepted by the block; it only paces the stimulus.
  int words_sent;

  jta_req_if req_ch();
  jta_rsp_if rsp_ch();

  journal_transaction_admission_core dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The checker watches both channels and the configuration port, keeps its
  // own copy of the journal state and reports mismatches through failures.
  journal_admission_checker admission_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_ch.valid),
    .req_ready    (req_ch.ready),
    .operation    (req_ch.operation),
    .block_number (req_ch.block_number),
    .rsp_valid    (rsp_ch.valid),
    .rsp_ready    (rsp_ch.ready),
    .status       (rsp_ch.status),
    .home_block   (rsp_ch.home_block),
    .slot_index   (rsp_ch.slot_index),
    .log_address  (rsp_ch.log_address),
    .pin_request  (rsp_ch.pin_request),
    .last         (rsp_ch.last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .outstanding  (outstanding),
    .failures     (failures)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle stretches are mostly absent or short, with an occasional long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The receiver toggles rsp ready at random. When the stimulus asks for a
  // long hold-off, it keeps ready low for a fixed count of cycles while the
  // sender keeps offering words, so the block has to back-pressure its input.
  initial begin : receiver
    int hold_left;
    int seen;
    hold_left = 0;
    seen = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req != seen) begin
        seen = long_hold_req;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_left = 0;
      end else if (hold_left > 0) begin
        hold_left--;
      end else begin
        rsp_ch.ready <= steady || ($urandom_range(0, 3) != 0);
        hold_left = idle_len();
      end
    end
  end

  // Offers one request word and waits for the handshake. Valid stays high
  // when no gap follows, so back-to-back words never drop it in between.
  task automatic offer(input op_t op, input logic [31:0] blk);
    int gap;
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.block_number <= blk;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    words_sent++;
    gap = idle_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every predicted word has come back. The
  // first edge lets the checker see the last accepted request before the
  // outstanding count is trusted.
  task automatic wait_drained(input int settle);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges. This is only called
  // after wait_drained, so the block is idle.
  task automatic write_regs(input logic [31:0] start, input int area, input int worst);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LOG_START;
    cfg_data  <= start;
    @(posedge clk);
    cfg_index <= REG_LOG_AREA_SIZE;
    cfg_data  <= 32'(area);
    @(posedge clk);
    cfg_index <= REG_MAX_OP_BLOCKS;
    cfg_data  <= 32'(worst);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // A well-formed group commit: one or more operations open, write blocks drawn
  // partly from a small pool so that repeats get absorbed, close, and then
  // usually the mover reports the commit as done.
  task automatic txn_group(input int n_ops, input int n_writes, input logic [31:0] pool);
    int k;
    for (k = 0; k < n_ops; k++) offer(OP_BEGIN, $urandom);
    for (k = 0; k < n_writes; k++)
      offer(OP_WRITE, ($urandom_range(0, 1) == 1) ? pool + $urandom_range(0, 7) : $urandom);
    for (k = 0; k < n_ops; k++) offer(OP_END, $urandom);
    if ($urandom_range(0, 6) != 0) offer(OP_DONE, $urandom);
  endtask

  // Random words of any operation, which also breaks up the sequences.
  task automatic noise_burst(input int n);
    int k;
    for (k = 0; k < n; k++) offer(op_t'($urandom_range(0, 3)), $urandom);
  endtask

  task automatic random_section(input int n_words, input logic [31:0] start,
                                input int area, input int worst);
    int goal;
    int pick;
    wait_drained(4);
    write_regs(start, area, worst);
    goal = words_sent + n_words;
    while (words_sent < goal) begin
      pick = $urandom_range(0, 19);
      steady = ($urandom_range(0, 6) == 0);
      if (pick < 14) begin
        txn_group($urandom_range(1, 3), $urandom_range(0, 12), $urandom);
      end else if (pick < 19) begin
        noise_burst($urandom_range(1, 4));
      end else begin
        wait_drained(0);
      end
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    int i;
    logic [31:0] base;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = REG_LOG_START;
    cfg_data            = '0;
    req_ch.valid        = 1'b0;
    req_ch.operation    = OP_BEGIN;
    req_ch.block_number = '0;
    steady              = 1'b0;
    long_hold_req       = 0;
    words_sent          = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Default configuration straight out of reset. Misuse comes first: an
    // end with nothing open, a commit done with no commit and a write
    // outside any operation. Then three operations fill the worst-case
    // budget, so a fourth begin has to wait.
    offer(OP_END, 32'h0);
    offer(OP_DONE, 32'hFFFF_FFFF);
    offer(OP_WRITE, 32'h0);
    offer(OP_BEGIN, 32'h0);
    offer(OP_BEGIN, 32'h0);
    offer(OP_BEGIN, 32'h0);
    offer(OP_BEGIN, 32'h0);
    // Extreme block numbers, with one repeat that must be absorbed.
    offer(OP_WRITE, 32'hFFFF_FFFF);
    offer(OP_WRITE, 32'h0);
    offer(OP_WRITE, 32'hFFFF_FFFF);
    offer(OP_WRITE, 32'hA5A5_5A5A);
    // The third end closes the last operation and starts the commit.
    offer(OP_END, 32'h0);
    offer(OP_END, 32'h0);
    offer(OP_END, 32'h0);
    // While committing, a begin waits, a write is outside any operation and
    // an end is rejected. Then the commit is retired, and a second done finds no commit.
    offer(OP_BEGIN, 32'h0);
    offer(OP_WRITE, 32'h1);
    offer(OP_END, 32'h0);
    offer(OP_DONE, 32'h0);
    offer(OP_DONE, 32'h0);
    // An operation that logs nothing gives an empty commit.
    offer(OP_BEGIN, 32'h0);
    offer(OP_END, 32'h0);

    // A log area large enough that the table fills all of its slots. The log base
    // sits near the top of the address space, so slot addresses wrap.
    wait_drained(4);
    write_regs(32'hFFFF_FFF0, 65, 4);
    base = $urandom;
    offer(OP_BEGIN, 32'h0);
    for (i = 0; i < 32; i++) offer(OP_WRITE, base + 32'(i));
    // With the table full, even a repeated block is refused as too big.
    offer(OP_WRITE, base);
    offer(OP_WRITE, ~base);
    // The receiver holds off while the full commit is emitted; the sender
    // keeps pushing words behind it so the input stalls.
    long_hold_req++;
    offer(OP_END, 32'h0);
    offer(OP_END, 32'h0);
    offer(OP_BEGIN, 32'h0);
    offer(OP_DONE, 32'h0);
    offer(OP_WRITE, base);
    // The sender pauses here until every expected word has arrived.
    wait_drained(0);
    txn_group(2, 10, $urandom);
    txn_group(1, 6, $urandom);

    // A log area of two blocks leaves room for a single logged block.
    wait_drained(4);
    write_regs(32'h0, 2, 1);
    base = $urandom;
    offer(OP_BEGIN, 32'h0);
    offer(OP_WRITE, base);
    offer(OP_WRITE, base);
    offer(OP_BEGIN, 32'h0);
    offer(OP_END, 32'h0);
    offer(OP_END, 32'h0);
    offer(OP_DONE, 32'h0);

    // A log area of zero refuses every write; one operation may use the
    // whole table, so a second begin waits.
    wait_drained(4);
    write_regs($urandom, 0, 32);
    offer(OP_BEGIN, 32'h0);
    offer(OP_BEGIN, 32'h0);
    offer(OP_WRITE, $urandom);
    offer(OP_END, 32'h0);

    // Random sections under several settings.
    random_section(RANDOM_WORDS / 3, $urandom, $urandom_range(33, 65), $urandom_range(1, 6));
    random_section(RANDOM_WORDS / 3, $urandom, $urandom_range(2, 20), $urandom_range(1, 12));
    random_section(RANDOM_WORDS / 3, 32'hFFFF_FFFF - $urandom_range(0, 40), 65, 1);

    // With a worst case of zero blocks only the open counter limits begins.
    // A commit left running by the random part is retired first. The
    // counter then saturates, the next begin waits, and a log area of one
    // refuses writes. The operations stay open until the run ends.
    wait_drained(4);
    write_regs(32'hFFFF_FFFF, 1, 0);
    offer(OP_DONE, 32'h0);
    steady = 1'b1;
    for (i = 0; i < 128; i++) offer(OP_BEGIN, 32'h0);
    offer(OP_WRITE, $urandom);
    steady = 1'b0;

    // Let the last words drain and leave the block a margin to misbehave.
    wait_drained(40);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guards against a hung handshake. The bound lies far above the slowest
  // correct run: long commits under long receiver stalls and long sender gaps.
  initial begin : watchdog
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- journal_transaction_admission_core.f -----
rtl/core/jta_pkg.sv
rtl/core/jta_req_if.sv
rtl/core/jta_rsp_if.sv
rtl/core/jta_log_ram.sv
rtl/core/jta_ctrl.sv
rtl/core/journal_transaction_admission_core.sv
tb/journal_admission_checker.sv
tb/journal_transaction_admission_core_test.sv
